FILE: src/hex_entity_escape_codec_macros.svh
// Assertion macros shared by the hex entity codec.
`ifndef HEX_ENTITY_ESCAPE_CODEC_MACROS_SVH
`define HEX_ENTITY_ESCAPE_CODEC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HECX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HECX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/hecx_pkg.sv
// Shared types, constants and helper functions of the hex entity codec.
package hecx_pkg;

   localparam int MAX_BEATS       = 5;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_UA   = 8'h41;
   localparam logic [7:0] CH_UF   = 8'h46;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LF   = 8'h66;

   localparam logic [6:0] SPECIAL_RESET = 7'd44;

   typedef enum logic [0:0] {
      REG_DECODE_MODE  = 1'b0,
      REG_SPECIAL_BYTE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_AMP   = 3'd1,
      PH_HASH  = 3'd2,
      PH_X     = 3'd3,
      PH_DIGIT = 3'd4
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [MAX_BEATS-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      last;
   } bundle_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (c >= CH_LA && c <= CH_LF) begin
         r.value = 4'(c - CH_LA + 8'd10);
      end else if (c >= CH_UA && c <= CH_UF) begin
         r.value = 4'(c - CH_UA + 8'd10);
      end else if (c >= CH_0 && c <= CH_9) begin
         r.value = c[3:0];
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = CH_0 + {4'd0, n};
      end else begin
         r = CH_LA + {4'd0, n} - 8'd10;
      end
      return r;
   endfunction

   function automatic logic [7:0] held_char(input logic [2:0] pos, input logic [7:0] digit);
      logic [7:0] r;
      unique case (pos)
         3'd0:    r = CH_AMP;
         3'd1:    r = CH_HASH;
         3'd2:    r = CH_X;
         default: r = digit;
      endcase
      return r;
   endfunction

endpackage

FILE: src/hecx_front.sv
// Front end: accepts input beats, holds configuration and tag state, builds output bundles.
module hecx_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_in_last,
   input  logic               csr_write_en,
   input  logic [0:0]         csr_index,
   input  logic [6:0]         csr_wdata,
   input  logic               q_full,
   output logic               push,
   output hecx_pkg::bundle_type bundle
);
   import hecx_pkg::*;

   logic       decode_mode_ff, decode_mode_in;
   logic [6:0] special_ff, special_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] nibble_ff, nibble_in;
   logic [7:0] digit_ff, digit_in;

   logic       accept;
   logic       mode_write;
   logic [7:0] c;
   hex_type    hv;
   logic       match;
   phase_type  scan_phase;
   logic       has_body;
   logic [7:0] body;
   logic [7:0] digit;
   logic [2:0] pre_len;
   logic [2:0] held_len;
   logic       has_x;
   logic [7:0] x_byte;
   logic       special_hit;

   assign c          = req_in_byte;
   assign hv         = hex_decode(c);
   assign req_ready  = !q_full;
   assign accept     = req_valid && !q_full;
   assign mode_write = csr_write_en && (reg_index_type'(csr_index) == REG_DECODE_MODE);

   // Tag matcher: classify the byte against the held partial tag.
   always_comb begin
      match      = 1'b0;
      scan_phase = PH_IDLE;
      has_body   = 1'b0;
      body       = c;
      unique case (phase_ff)
         PH_AMP:            match = (c == CH_HASH);
         PH_HASH:           match = (c == CH_X);
         PH_X, PH_DIGIT:    match = hv.valid;
         default:           match = 1'b0;
      endcase
      if (!match) begin
         if (c == CH_AMP) begin
            scan_phase = PH_AMP;
         end else begin
            has_body = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_AMP:   scan_phase = PH_HASH;
            PH_HASH:  scan_phase = PH_X;
            PH_X:     scan_phase = PH_DIGIT;
            PH_DIGIT: begin
               has_body = 1'b1;
               body     = {nibble_ff, hv.value};
            end
            default:  scan_phase = PH_IDLE;
         endcase
      end
      pre_len = (phase_ff != PH_IDLE && !match) ? 3'(phase_ff) : 3'd0;
      digit   = (phase_ff == PH_X && match) ? c : digit_ff;
   end

   // Next state.
   always_comb begin
      decode_mode_in = decode_mode_ff;
      special_in     = special_ff;
      phase_in       = phase_ff;
      nibble_in      = nibble_ff;
      digit_in       = digit_ff;
      if (accept && decode_mode_ff) begin
         phase_in = req_in_last ? PH_IDLE : scan_phase;
         if (phase_ff == PH_X && match) begin
            nibble_in = hv.value;
            digit_in  = c;
         end
      end
      if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_DECODE_MODE: begin
               decode_mode_in = csr_wdata[0];
               phase_in       = PH_IDLE;
               nibble_in      = 4'd0;
               digit_in       = 8'd0;
            end
            REG_SPECIAL_BYTE: special_in = csr_wdata;
            default:          special_in = special_ff;
         endcase
      end
   end

   // Bundles: entity or plain byte (escape); held tag bytes and at most one more (decode).
   always_comb begin
      special_hit = (c == CH_AMP) || (c == {1'b0, special_ff});
      held_len    = 3'd0;
      has_x       = 1'b0;
      x_byte      = has_body ? body : CH_AMP;
      if (pre_len != 3'd0) begin
         held_len = pre_len;
         has_x    = has_body || (req_in_last && scan_phase == PH_AMP);
      end else if (has_body) begin
         has_x = 1'b1;
      end else if (req_in_last) begin
         held_len = 3'(scan_phase);
      end
      bundle.last = req_in_last;
      if (!decode_mode_ff) begin
         if (special_hit) begin
            bundle.bytes[0] = CH_AMP;
            bundle.bytes[1] = CH_HASH;
            bundle.bytes[2] = CH_X;
            bundle.bytes[3] = hex_char(c[7:4]);
            bundle.bytes[4] = hex_char(c[3:0]);
            bundle.count    = 3'(MAX_BEATS);
         end else begin
            for (int i = 0; i < MAX_BEATS; i++) begin
               bundle.bytes[i] = c;
            end
            bundle.count = 3'd1;
         end
      end else begin
         for (int i = 0; i < MAX_BEATS; i++) begin
            bundle.bytes[i] = (3'(i) < held_len) ? held_char(3'(i), digit) : x_byte;
         end
         bundle.count = held_len + {2'd0, has_x};
      end
      push = accept && (bundle.count != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         special_ff     <= SPECIAL_RESET;
         phase_ff       <= PH_IDLE;
         nibble_ff      <= 4'd0;
         digit_ff       <= 8'd0;
      end else begin
         decode_mode_ff <= decode_mode_in;
         special_ff     <= special_in;
         phase_ff       <= phase_in;
         nibble_ff      <= nibble_in;
         digit_ff       <= digit_in;
      end
   end

endmodule

FILE: src/hecx_queue.sv
// Short bundle queue between the front end and the output serializer.
module hecx_queue #(
   parameter int QUEUE_DEPTH = hecx_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hecx_pkg::bundle_type wr_data,
   input  logic                 pop,
   output hecx_pkg::bundle_type rd_data,
   output logic                 q_valid,
   output logic                 q_full
);
   import hecx_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/hecx_back.sv
// Back end: serializes each queued bundle into output beats.
module hecx_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hecx_pkg::bundle_type rd_data,
   input  logic                 q_valid,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last,
   output logic                 rsp_end_of_string
);
   import hecx_pkg::*;

   bundle_type cur_ff, cur_in;
   logic [2:0] remain_ff, remain_in;
   logic       valid_ff, valid_in;
   logic       beat;
   logic       load;

   assign beat              = valid_ff && rsp_ready;
   assign load              = !valid_ff || (beat && remain_ff == 3'd1);
   assign pop               = load && q_valid;
   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = cur_ff.bytes[0];
   assign rsp_out_last      = (remain_ff == 3'd1);
   assign rsp_end_of_string = (remain_ff == 3'd1) && cur_ff.last;

   always_comb begin
      cur_in    = cur_ff;
      remain_in = remain_ff;
      valid_in  = valid_ff;
      if (load) begin
         valid_in  = q_valid;
         cur_in    = rd_data;
         remain_in = rd_data.count;
      end else if (beat) begin
         cur_in.bytes = cur_ff.bytes >> 8;
         remain_in    = remain_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      remain_ff <= remain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: src/hex_entity_escape_codec.sv
// Top level of the hex entity codec: front end, bundle queue and output serializer.
// An accepted item is written into a queue entry, then loaded into the serializer, which
// presents its first output beat. Throughput: one input beat per cycle while the output is
// ready and each item yields one byte; an item of up to five bytes holds the output port for
// one beat per byte, and the input waits while the queue (two entries by default) is full.
// Reset clears all control state, selects escape mode and sets the separator byte to 44.
module hex_entity_escape_codec #(
   parameter int QUEUE_DEPTH = hecx_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_end_of_string,
   input  logic       csr_write_en,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_wdata
);
   import hecx_pkg::*;

`include "hex_entity_escape_codec_macros.svh"

   bundle_type wr_bundle;
   bundle_type rd_bundle;
   logic       push;
   logic       pop;
   logic       q_valid;
   logic       q_full;

   hecx_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .push         (push),
      .bundle       (wr_bundle)
   );

   hecx_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_bundle),
      .pop     (pop),
      .rd_data (rd_bundle),
      .q_valid (q_valid),
      .q_full  (q_full)
   );

   hecx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .rd_data           (rd_bundle),
      .q_valid           (q_valid),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_end_of_string (rsp_end_of_string)
   );

   `HECX_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !q_full, "push into a full queue")
   `HECX_ASSERT_NOW(a_pop_needs_entry, clock, reset, pop, q_valid, "pop from an empty queue")
   `HECX_ASSERT_NOW(a_eos_on_last, clock, reset, rsp_valid && rsp_end_of_string, rsp_out_last, "stray eos")
   `HECX_ASSERT_NEXT(a_push_fills_queue, clock, reset, push && !pop, q_valid, "lost push")

endmodule

FILE: tb/sv/hex_entity_escape_codec_tb.sv
// Self-checking testbench for the hex entity escape/unescape codec.
`timescale 1ns / 1ps

module hex_entity_escape_codec_tb;
   import hecx_pkg::*;

   localparam int RANDOM_ITEMS = 430;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 40;
   localparam logic [7:0] CH_UX = 8'h58;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       eos;
   } beat_type;

   typedef struct packed {
      logic          is_write;
      reg_index_type idx;
      logic [7:0]    value;
      logic          last;
      logic [2:0]    typed_n;
      logic [39:0]   typed;
   } row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_end_of_string;
   logic       csr_write_en = 1'b0;
   logic [0:0] csr_index = 1'b0;
   logic [6:0] csr_wdata = 7'd0;

   logic [2:0]  typed_count = 3'd0;
   logic [39:0] typed_text = 40'd0;

   logic       dec_mode;
   logic [6:0] sep_byte;
   phase_type  tag_state;
   logic [3:0] hi_nibble;
   logic [7:0] digit_held;

   beat_type   step_beats[$];
   beat_type   expected_beats[$];
   logic [7:0] text_bytes[$];
   row_type    directed_rows[$];

   bit no_idle = 1'b0;
   bit long_hold = 1'b0;
   int failures = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   int beats_checked = 0;
   int csr_writes = 0;
   int hold_count = 0;
   int cycle_count = 0;

   string hex_set = "0123456789abcdefABCDEF";

   hex_entity_escape_codec uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_in_last(req_in_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last),
      .rsp_end_of_string(rsp_end_of_string),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      return -1;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      return (n < 4'd10) ? CH_0 + 8'(n) : CH_LA + 8'(n - 4'd10);
   endfunction

   function automatic row_type item_row(input logic [7:0] b, input logic l,
                                        input logic [2:0] n, input logic [39:0] t);
      return '{1'b0, REG_DECODE_MODE, b, l, n, t};
   endfunction

   function automatic row_type csr_row(input reg_index_type idx, input logic [7:0] d);
      return '{1'b1, idx, d, 1'b0, 3'd0, 40'd0};
   endfunction

   task automatic emit(input logic [7:0] b);
      beat_type nb;
      nb = '{data: b, last: 1'b0, eos: 1'b0};
      step_beats = {step_beats, nb};
   endtask

   task automatic flush_held();
      if (tag_state >= PH_AMP) emit(CH_AMP);
      if (tag_state >= PH_HASH) emit(CH_HASH);
      if (tag_state >= PH_X) emit(CH_X);
      if (tag_state >= PH_DIGIT) emit(digit_held);
      tag_state = PH_IDLE;
   endtask

   task automatic predict_bytes(input logic [7:0] c, input logic last_in,
                                input logic [2:0] tn, input logic [39:0] tt);
      int v;
      bit done;
      step_beats.delete();
      if (!dec_mode) begin
         if (c == CH_AMP || c == {1'b0, sep_byte}) begin
            emit(CH_AMP);
            emit(CH_HASH);
            emit(CH_X);
            emit(digit_char(c[7:4]));
            emit(digit_char(c[3:0]));
         end else begin
            emit(c);
         end
      end else begin
         done = 1'b0;
         for (int pass = 0; pass < 2 && !done; pass++) begin
            v = nibble_of(c);
            done = 1'b1;
            if (tag_state == PH_IDLE) begin
               if (c == CH_AMP) tag_state = PH_AMP;
               else emit(c);
            end else if (tag_state == PH_AMP && c == CH_HASH) begin
               tag_state = PH_HASH;
            end else if (tag_state == PH_HASH && c == CH_X) begin
               tag_state = PH_X;
            end else if (tag_state == PH_X && v >= 0) begin
               digit_held = c;
               hi_nibble = v[3:0];
               tag_state = PH_DIGIT;
            end else if (tag_state == PH_DIGIT && v >= 0) begin
               emit({hi_nibble, v[3:0]});
               tag_state = PH_IDLE;
            end else begin
               flush_held();
               done = 1'b0;
            end
         end
         if (last_in) flush_held();
      end
      if (tn != 3'd0) begin
         step_beats.delete();
         for (int k = 0; k < int'(tn); k++) emit(tt[8*(int'(tn)-1-k) +: 8]);
      end
      if (step_beats.size() > 0) begin
         step_beats[step_beats.size()-1].last = 1'b1;
         step_beats[step_beats.size()-1].eos = last_in;
      end
      expected_beats = {expected_beats, step_beats};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dec_mode = 1'b0;
         sep_byte = SPECIAL_RESET;
         tag_state = PH_IDLE;
         hi_nibble = 4'd0;
         digit_held = 8'd0;
      end else begin
         if (csr_write_en) begin
            case (reg_index_type'(csr_index))
               REG_DECODE_MODE: begin
                  dec_mode = csr_wdata[0];
                  tag_state = PH_IDLE;
                  hi_nibble = 4'd0;
                  digit_held = 8'd0;
               end
               REG_SPECIAL_BYTE: sep_byte = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_bytes(req_in_byte, req_in_last, typed_count, typed_text);
         end
      end
   end

   always @(posedge clock) begin
      beat_type exp_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat: expected none, actual byte %02h last %b eos %b",
                     $time, rsp_out_byte, rsp_out_last, rsp_end_of_string);
            failures++;
         end else begin
            exp_beat = expected_beats.pop_front();
            if (rsp_out_byte !== exp_beat.data) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, exp_beat.data, rsp_out_byte);
               failures++;
            end
            if (rsp_out_last !== exp_beat.last) begin
               $display("%0t: out_last mismatch: expected %b, actual %b",
                        $time, exp_beat.last, rsp_out_last);
               failures++;
            end
            if (rsp_end_of_string !== exp_beat.eos) begin
               $display("%0t: end_of_string mismatch: expected %b, actual %b",
                        $time, exp_beat.eos, rsp_end_of_string);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d beats still expected",
                  $time, cycle_count, expected_beats.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            hold_count++;
         end
         wait_cycles = no_idle ? 0 : $urandom_range(0, 11);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic l,
                            input logic [2:0] tn, input logic [39:0] tt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      typed_count <= tn;
      typed_text <= tt;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (l) strings_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [6:0] d);
      req_valid <= 1'b0;
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_writes++;
   endtask

   task automatic push_tag(input int upto);
      for (int k = 0; k < upto; k++) begin
         case (k)
            0: text_bytes = {text_bytes, CH_AMP};
            1: text_bytes = {text_bytes, CH_HASH};
            2: text_bytes = {text_bytes, CH_X};
            default: text_bytes = {text_bytes, 8'(hex_set[$urandom_range(0, 21)])};
         endcase
      end
   endtask

   task automatic build_text(input logic mode, input logic [6:0] sep);
      int r;
      text_bytes.delete();
      if (!mode) begin
         repeat ($urandom_range(1, 8)) begin
            r = $urandom_range(0, 3);
            if (r == 0) text_bytes = {text_bytes, CH_AMP};
            else if (r == 1) text_bytes = {text_bytes, {1'b0, sep}};
            else text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
         end
      end else begin
         repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 9);
            if (r <= 4) begin
               push_tag(5);
            end else if (r == 5) begin
               push_tag($urandom_range(1, 4));
            end else if (r == 6) begin
               text_bytes = {text_bytes, CH_AMP};
               text_bytes = {text_bytes, CH_HASH};
               text_bytes = {text_bytes, CH_UX};
            end else begin
               text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
            end
         end
      end
   endtask

   initial begin
      int phase_no;
      int decode_phases;
      int target;
      logic mode;
      logic [6:0] sep;

      directed_rows = '{
         item_row("A", 1'b0, 3'd1, "A"),
         item_row(CH_AMP, 1'b0, 3'd5, "&#x26"),
         item_row(8'd44, 1'b0, 3'd5, "&#x2c"),
         item_row(8'hFF, 1'b1, 3'd0, 40'd0),
         csr_row(REG_SPECIAL_BYTE, 8'd0),
         item_row(8'h00, 1'b0, 3'd5, "&#x00"),
         csr_row(REG_SPECIAL_BYTE, 8'd127),
         item_row(8'h7F, 1'b1, 3'd5, "&#x7f"),
         item_row(8'd44, 1'b1, 3'd1, ","),
         csr_row(REG_DECODE_MODE, 8'd1),
         item_row(CH_AMP, 1'b0, 3'd0, 40'd0),
         item_row(CH_AMP, 1'b0, 3'd1, "&"),
         item_row(CH_HASH, 1'b0, 3'd0, 40'd0),
         item_row(CH_X, 1'b0, 3'd0, 40'd0),
         item_row("4", 1'b0, 3'd0, 40'd0),
         item_row("a", 1'b0, 3'd1, "J"),
         item_row(CH_AMP, 1'b0, 3'd0, 40'd0),
         item_row(CH_HASH, 1'b0, 3'd0, 40'd0),
         item_row(CH_UX, 1'b0, 3'd3, "&#X"),
         item_row(CH_AMP, 1'b0, 3'd0, 40'd0),
         item_row(CH_HASH, 1'b0, 3'd0, 40'd0),
         item_row(CH_X, 1'b0, 3'd0, 40'd0),
         item_row("7", 1'b1, 3'd4, "&#x7"),
         item_row(CH_AMP, 1'b0, 3'd0, 40'd0),
         csr_row(REG_DECODE_MODE, 8'd1),
         item_row("B", 1'b1, 3'd1, "B")
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            write_csr(directed_rows[i].idx, directed_rows[i].value[6:0]);
         end else begin
            send_byte(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed_n, directed_rows[i].typed);
         end
      end

      phase_no = 0;
      decode_phases = 0;
      target = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < target) begin
         if (phase_no < 2) mode = 1'b0;
         else if (phase_no < 4) mode = 1'b1;
         else mode = 1'($urandom_range(0, 1));
         if (phase_no == 0) sep = 7'd0;
         else if (phase_no == 1) sep = 7'd127;
         else if ($urandom_range(0, 3) == 0) sep = SPECIAL_RESET;
         else sep = 7'($urandom_range(0, 127));
         write_csr(REG_SPECIAL_BYTE, sep);
         write_csr(REG_DECODE_MODE, {6'($urandom_range(0, 63)), mode});
         no_idle = (phase_no == 1) || ($urandom_range(0, 3) == 0);
         if (phase_no == 1) long_hold = 1'b1;
         if (mode) decode_phases++;
         while (bytes_sent < target && bytes_sent < csr_writes * 0 + target
                && (bytes_sent - (target - RANDOM_ITEMS)) < (phase_no + 1) * PHASE_ITEMS) begin
            build_text(mode, sep);
            foreach (text_bytes[k]) begin
               send_byte(text_bytes[k], k == text_bytes.size() - 1, 3'd0, 40'd0);
            end
         end
         phase_no++;
      end

      req_valid <= 1'b0;
      no_idle = 1'b0;
      wait_drained();

      $display("Sent %0d bytes in %0d strings across %0d setting phases (%0d decoding),",
               bytes_sent, strings_sent, phase_no, decode_phases);
      $display("%0d register writes; checked %0d output beats with %0d mismatches.",
               csr_writes, beats_checked, failures);
      $display("Output held off %0d time(s) for %0d cycles.", hold_count, HOLD_CYCLES);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
